/* rtl/dds_pkg.sv */
// Shared types and constants for the disk data separator DPLL.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package dds_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int OFFSET_BITS   = 16;
    localparam int MAX_OUT       = 64;

    localparam int CFG_W   = 10;
    localparam int WIN_W   = 11;
    localparam int PHASE_W = 13;
    localparam int CYC_W   = 8;
    localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W   = OFFSET_BITS + HIST_IDX_W + 1;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);
    localparam logic [CFG_W-1:0] CPB_RESET = CFG_W'(32);
    localparam logic [CFG_W-1:0] TOL_RESET = CFG_W'(3);
    localparam logic [WIN_W-1:0] WIN_FLOOR = WIN_W'(4);

    localparam logic REG_CPB = 1'b0;
    localparam logic REG_TOL = 1'b1;

    typedef enum logic {
        KIND_ADVANCE = 1'b0,
        KIND_PULSE   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [CYC_W-1:0] cycles;
    } item_t;

endpackage
`default_nettype wire

/* rtl/dds_front.sv */
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on dds_pkg.
`default_nettype none
module dds_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           mode,
    input  wire logic [7:0]     cycles,
    output logic                q_valid,
    input  wire logic           q_pop,
    output dds_pkg::item_t      q_item
);
    import dds_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;
    item_t       new_item;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        new_item.kind   = mode ? KIND_PULSE : KIND_ADVANCE;
        new_item.cycles = cycles;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/dds_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on dds_pkg for the operand width.
`default_nettype none
module dds_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [dds_pkg::SUM_W-1:0] dividend,
    input  wire logic [dds_pkg::SUM_W-1:0] divisor,
    output logic                           done,
    output logic [dds_pkg::SUM_W-1:0]      quotient,
    output logic [dds_pkg::SUM_W-1:0]      remainder
);
    import dds_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;

    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[SUM_W])
            begin
                rem_reg <= diff[SUM_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[SUM_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/dds_core.sv */
// Back end: phase tracking, bit emission, spacing history and window length update.
// Depends on dds_pkg and dds_div.
`default_nettype none
module dds_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [dds_pkg::CFG_W-1:0] bit_period,
    input  wire logic [dds_pkg::CFG_W-1:0] tolerance,
    input  wire logic                      q_valid,
    output logic                           q_pop,
    input  wire dds_pkg::item_t            q_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           bit_value,
    output logic                           last
);
    import dds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PDIV,
        S_ZERO,
        S_POUT,
        S_MLAUNCH,
        S_MWAIT,
        S_WLAUNCH,
        S_WWAIT,
        S_PHASE
    } state_t;

    state_t                 state_reg;
    logic [PHASE_W-1:0]     phase_reg;
    logic [WIN_W-1:0]       window_len_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] hist_reg [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0]  ptr_reg;
    logic [HIST_IDX_W-1:0]  idx_reg;
    logic                   filled_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SUM_W-1:0]       msum_reg;
    logic [SUM_W-1:0]       ssum_reg;
    logic                   out_valid_reg;
    logic                   bit_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   out_load;
    logic [PHASE_W-1:0]     adv_phase;
    logic [OFFSET_BITS:0]   off_sum;
    logic [OFFSET_BITS-1:0] off_sat;
    logic [CFG_W-1:0]       den;
    logic [CFG_W-1:0]       half;
    logic [OFFSET_BITS-1:0] hist_rd;
    logic [WIN_W-1:0]       hi;
    logic [WIN_W-1:0]       lo;
    logic [SUM_W-1:0]       crossed;
    logic [CNT_W-1:0]       nbits;
    logic [SUM_W-1:0]       wq;
    logic [WIN_W-1:0]       wclamp;
    logic signed [PHASE_W+1:0] err1;
    logic signed [PHASE_W+1:0] phase_pull;

    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    logic [SUM_W-1:0]       div_divisor;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    logic [SUM_W-1:0]       div_rem;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && ((state_reg == S_ZERO) || (state_reg == S_POUT));
    assign out_valid = out_valid_reg;
    assign bit_value = bit_reg;
    assign last      = last_reg;
    assign q_pop     = (state_reg == S_IDLE);

    assign adv_phase = phase_reg + PHASE_W'(q_item.cycles);
    assign off_sum   = {1'b0, offset_reg} + (OFFSET_BITS + 1)'(q_item.cycles);
    assign off_sat   = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
    assign den       = (bit_period == '0) ? CFG_W'(1) : bit_period;
    assign half      = bit_period >> 1;
    assign hist_rd   = hist_reg[idx_reg];

    // Clamp bounds; the lower bound wins when the two cross.
    assign hi = WIN_W'(bit_period) + WIN_W'(tolerance);
    assign lo = (WIN_W'(bit_period) >= WIN_W'(tolerance) + WIN_FLOOR)
                ? WIN_W'(bit_period) - WIN_W'(tolerance) : WIN_FLOOR;

    assign crossed = div_quo - SUM_W'(filled_reg);
    assign nbits   = (crossed > SUM_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : crossed[CNT_W-1:0];

    always_comb
    begin
        wq = div_quo;
        if (wq > SUM_W'(hi))
        begin
            wq = SUM_W'(hi);
        end
        if (wq < SUM_W'(lo))
        begin
            wq = SUM_W'(lo);
        end
        wclamp = wq[WIN_W-1:0];
    end

    // Pull the phase halfway towards the window center, rounding the halved error up.
    assign err1 = $signed({2'b00, phase_reg}) - $signed((PHASE_W + 2)'(window_len_reg >> 1))
                  + $signed((PHASE_W + 2)'(1));
    assign phase_pull = $signed({2'b00, phase_reg}) - (err1 >>> 1);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = SUM_W'(adv_phase);
        div_divisor  = SUM_W'(window_len_reg);
        case (state_reg)
            S_IDLE:
            begin
                div_start = q_valid && (q_item.kind == KIND_ADVANCE)
                            && (adv_phase >= PHASE_W'(window_len_reg));
            end
            S_MLAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = SUM_W'(hist_rd) + SUM_W'(half);
                div_divisor  = SUM_W'(den);
            end
            S_WLAUNCH:
            begin
                div_start    = (msum_reg != '0);
                div_dividend = ssum_reg;
                div_divisor  = msum_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    dds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= '0;
            window_len_reg <= WIN_RESET;
            offset_reg     <= '0;
            ptr_reg        <= '0;
            idx_reg        <= '0;
            filled_reg     <= 1'b0;
            cnt_reg        <= '0;
            msum_reg       <= '0;
            ssum_reg       <= '0;
            out_valid_reg  <= 1'b0;
            bit_reg        <= 1'b0;
            last_reg       <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.kind == KIND_ADVANCE)
                        begin
                            offset_reg <= off_sat;
                            phase_reg  <= adv_phase;
                            if (adv_phase >= PHASE_W'(window_len_reg))
                            begin
                                state_reg <= S_PDIV;
                            end
                        end
                        else if (!filled_reg)
                        begin
                            state_reg <= S_POUT;
                        end
                    end
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        phase_reg  <= div_rem[PHASE_W-1:0];
                        filled_reg <= 1'b0;
                        cnt_reg    <= nbits;
                        state_reg  <= (nbits == '0) ? S_IDLE : S_ZERO;
                    end
                end
                S_ZERO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        bit_reg       <= 1'b0;
                        last_reg      <= (cnt_reg == CNT_W'(1));
                        cnt_reg       <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_POUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        bit_reg           <= 1'b1;
                        last_reg          <= 1'b1;
                        filled_reg        <= 1'b1;
                        hist_reg[ptr_reg] <= offset_reg;
                        ptr_reg           <= (ptr_reg == HIST_IDX_W'(HISTORY_DEPTH - 1))
                                             ? '0 : ptr_reg + HIST_IDX_W'(1);
                        offset_reg        <= '0;
                        idx_reg           <= '0;
                        msum_reg          <= '0;
                        ssum_reg          <= '0;
                        state_reg         <= S_MLAUNCH;
                    end
                end
                S_MLAUNCH:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        if (div_quo != '0)
                        begin
                            msum_reg <= msum_reg + div_quo;
                            ssum_reg <= ssum_reg + SUM_W'(hist_rd);
                        end
                        if (idx_reg == HIST_IDX_W'(HISTORY_DEPTH - 1))
                        begin
                            state_reg <= S_WLAUNCH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + HIST_IDX_W'(1);
                            state_reg <= S_MLAUNCH;
                        end
                    end
                end
                S_WLAUNCH:
                begin
                    state_reg <= (msum_reg != '0) ? S_WWAIT : S_PHASE;
                end
                S_WWAIT:
                begin
                    if (div_done)
                    begin
                        window_len_reg <= wclamp;
                        state_reg      <= S_PHASE;
                    end
                end
                S_PHASE:
                begin
                    phase_reg <= phase_pull[PHASE_W-1:0];
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/disk_data_separator_dpll.sv */
// Top level of the disk data separator DPLL: configuration registers and block wiring.
// Depends on dds_pkg, dds_front and dds_core (which holds dds_div).
//
// This block turns a stream of flux events into recovered data bits. Each input beat
// either advances time by "cycles" clocks (mode 0) or reports one flux pulse (mode 1).
// A time advance that crosses one or more bit windows produces a 0 beat for every window
// crossed, less the window a pulse already filled, capped at 64; the final beat carries
// last. The first pulse in a window produces a single 1 beat with last set, logs the
// spacing since the previous pulse into an eight-entry history and retunes the window
// length from that history, clamped around the nominal bit period by tolerance. Input
// beats pass through a two-entry queue, so the source can run up to two beats ahead of
// the back end; once the queue is full, in_ready drops until the back end takes a beat.
// All divisions go through one shared restoring divider: an advance that stays inside
// the window needs none, one that crosses windows needs one before its bits go out, and
// a pulse needs one per history entry plus at most one for the window length. Registers:
// the nominal bit period at byte address 0 (reset 32), tolerance at 4 (reset 3); a write
// becomes effective at the next window length update.
`default_nettype none
module disk_data_separator_dpll (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  cycles,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             bit_value,
    output logic             last
);
    import dds_pkg::*;

    logic [CFG_W-1:0] cpb_reg;
    logic [CFG_W-1:0] tol_reg;
    logic             q_valid;
    logic             q_pop;
    item_t            q_item;

    assign pready = 1'b1;

    // Register index comes from address bit 2; both registers are 10 bits wide.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpb_reg <= CPB_RESET;
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_CPB)
            begin
                cpb_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                tol_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CPB) ? 32'(cpb_reg) : 32'(tol_reg);

    dds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .cycles   (cycles),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    dds_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_period (cpb_reg),
        .tolerance  (tol_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bit_value  (bit_value),
        .last       (last)
    );

endmodule
`default_nettype wire

/* tb/tb_disk_data_separator_dpll.sv */
// Self-checking testbench for the disk data separator DPLL.
// Depends on dds_pkg and disk_data_separator_dpll; drives random and directed beats,
// predicts the recovered bits in SystemVerilog and compares them beat by beat.
`default_nettype none
module tb_disk_data_separator_dpll;
    import dds_pkg::*;

    localparam int ADDR_CPB = 0;
    localparam int ADDR_TOL = 4;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  cycles;
    logic        out_valid;
    logic        out_ready;
    logic        bit_value;
    logic        last;

    disk_data_separator_dpll dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .cycles(cycles),
        .out_valid(out_valid), .out_ready(out_ready),
        .bit_value(bit_value), .last(last)
    );

    // Predictor state, kept at the block's widths where that matters.
    int unsigned  cpb_reg;
    int unsigned  tol_reg;
    int           phase_acc;
    int unsigned  win_len;
    int unsigned  spacing_since_pulse;
    int unsigned  spacing_log [HISTORY_DEPTH];
    int unsigned  log_wr;
    bit           cell_filled;

    // Pending input beats and the recovered bits we expect, as {bit_value, last}.
    item_t        beats_pending[$];
    logic [1:0]   bits_expected[$];
    bit           failed;
    int           idle_cycles;
    bit           hold_sender;

    function automatic int halve_floor(int x);
        if (x >= 0)
            return x >>> 1;
        return -((-x + 1) >>> 1);
    endfunction

    // Retune the window from the spacing log after a pulse, then pull the phase in.
    task automatic retune_window();
        longint unsigned total;
        longint unsigned mult_sum;
        longint unsigned den;
        longint unsigned m;
        longint unsigned w;
        longint unsigned hi;
        longint unsigned lo;
        int err;
        total = 0;
        mult_sum = 0;
        den = (cpb_reg != 0) ? cpb_reg : 1;
        spacing_log[log_wr] = spacing_since_pulse;
        log_wr = (log_wr + 1) % HISTORY_DEPTH;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            m = (spacing_log[i] + (cpb_reg >> 1)) / den;
            if (m != 0)
            begin
                mult_sum += m;
                total += spacing_log[i];
            end
        end
        if (mult_sum != 0)
        begin
            w = total / mult_sum;
            hi = cpb_reg + tol_reg;
            lo = (cpb_reg >= tol_reg + 4) ? cpb_reg - tol_reg : 4;
            if (w > hi)
                w = hi;
            if (w < lo)
                w = lo;
            win_len = 32'(w);
        end
        err = phase_acc - int'(win_len >> 1);
        phase_acc = phase_acc - halve_floor(err + 1);
    endtask

    // Work out the bits that one accepted beat yields and queue them.
    task automatic predict_bits(item_t b);
        int unsigned win;
        int unsigned crossed;
        int unsigned n;
        win = (win_len != 0) ? win_len : 4;
        if (b.kind == KIND_ADVANCE)
        begin
            spacing_since_pulse += b.cycles;
            if (spacing_since_pulse > (1 << OFFSET_BITS) - 1)
                spacing_since_pulse = (1 << OFFSET_BITS) - 1;
            phase_acc += b.cycles;
            if (unsigned'(phase_acc) < win)
                return;
            crossed = unsigned'(phase_acc) / win;
            if (cell_filled)
                crossed--;
            n = (crossed > MAX_OUT) ? MAX_OUT : crossed;
            for (int k = 0; k < n; k++)
                bits_expected.push_back({1'b0, (k + 1 == n) ? 1'b1 : 1'b0});
            cell_filled = 0;
            phase_acc = unsigned'(phase_acc) % win;
        end
        else if (!cell_filled)
        begin
            bits_expected.push_back(2'b11);
            cell_filled = 1;
            retune_window();
            spacing_since_pulse = 0;
        end
    endtask

    // Most gaps are short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Sender: one beat at a time from the pending queue, with random gaps.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            mode <= 0;
            cycles <= 0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_bits(item_t'({mode, cycles}));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 0;
                    send_gap <= send_gap - 1;
                end
                else if (beats_pending.size() > 0 && !hold_sender)
                begin
                    item_t nb;
                    nb = beats_pending.pop_front();
                    in_valid <= 1;
                    mode <= nb.kind;
                    cycles <= nb.cycles;
                    send_gap <= gap_len();
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // Receiver: random stalls on out_ready; each accepted beat is checked.
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (bits_expected.size() == 0)
                begin
                    $display("%0t: unexpected bit beat bit_value=%0b last=%0b",
                             $time, bit_value, last);
                    failed = 1;
                end
                else
                begin
                    logic [1:0] exp_bits;
                    exp_bits = bits_expected.pop_front();
                    if (exp_bits[1] !== bit_value)
                    begin
                        $display("%0t: bit_value expected %0b actual %0b",
                                 $time, exp_bits[1], bit_value);
                        failed = 1;
                    end
                    if (exp_bits[0] !== last)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_bits[0], last);
                        failed = 1;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                out_ready <= 0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1;
                recv_gap <= gap_len();
            end
        end
    end

    // Watchdog: counts cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** disk_data_separator_dpll: FAILED **");
                $finish;
            end
        end
    end

    // Configuration write over the APB-style port; the predictor follows along.
    task automatic reg_write(int addr, int unsigned value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(addr);
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_CPB)
            cpb_reg = value & 32'h3FF;
        else
            tol_reg = value & 32'h3FF;
    endtask

    // Wait until every pending beat went in and every expected bit came out,
    // then let a pulse's worth of latency pass before touching registers.
    task automatic drain();
        while (beats_pending.size() != 0 || in_valid || bits_expected.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic queue_beat(kind_t k, int c);
        item_t b;
        b.kind = k;
        b.cycles = 8'(c);
        beats_pending.push_back(b);
    endtask

    // A well-formed flux stream: pulses spaced by one to four cells, with jitter,
    // and the advance split into a few beats. Some noise thrown in.
    task automatic queue_stream(int count);
        int period;
        int spacing;
        int chunk;
        period = (cpb_reg != 0) ? cpb_reg : 8;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_beat(kind_t'($urandom_range(0, 1)), $urandom_range(0, 255));
                continue;
            end
            spacing = period * $urandom_range(1, 4) + $urandom_range(0, 6) - 3;
            if (spacing < 0)
                spacing = 0;
            while (spacing > 0)
            begin
                chunk = (spacing > 255) ? 255 : $urandom_range(1, spacing);
                queue_beat(KIND_ADVANCE, chunk);
                spacing -= chunk;
                i++;
            end
            queue_beat(KIND_PULSE, $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        failed = 0;
        hold_sender = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        cpb_reg = 32;
        tol_reg = 3;
        phase_acc = 0;
        win_len = 32;
        spacing_since_pulse = 0;
        foreach (spacing_log[i])
            spacing_log[i] = 0;
        log_wr = 0;
        cell_filled = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: quiet advance, field extremes, a pulse into a filled cell
        // and many cells crossed.
        queue_beat(KIND_ADVANCE, 0);
        queue_beat(KIND_ADVANCE, 10);
        queue_beat(KIND_ADVANCE, 255);
        queue_beat(KIND_PULSE, 8'hFF);
        queue_beat(KIND_PULSE, 8'h00);
        queue_beat(KIND_ADVANCE, 32);
        queue_beat(KIND_ADVANCE, 8'hAA);
        queue_beat(KIND_PULSE, 8'h55);
        queue_beat(KIND_ADVANCE, 1);
        for (int i = 0; i < 10; i++)
            queue_beat(KIND_ADVANCE, 255);
        queue_beat(KIND_PULSE, 0);
        drain();

        // Smallest cell with wide tolerance: the lower bound falls to the floor.
        reg_write(ADDR_CPB, 8);
        reg_write(ADDR_TOL, 1019);
        queue_beat(KIND_ADVANCE, 255);
        queue_beat(KIND_ADVANCE, 255);
        queue_stream(40);
        drain();

        // Largest cell: long spacings.
        reg_write(ADDR_CPB, 1023);
        reg_write(ADDR_TOL, 0);
        for (int i = 0; i < 12; i++)
            queue_beat(KIND_ADVANCE, $urandom_range(200, 255));
        queue_beat(KIND_PULSE, 0);
        for (int i = 0; i < 10; i++)
            queue_beat(KIND_ADVANCE, 255);
        drain();

        // Zero cell length, written through the port even though out of range.
        reg_write(ADDR_CPB, 0);
        queue_beat(KIND_PULSE, 0);
        queue_beat(KIND_ADVANCE, 20);
        queue_beat(KIND_PULSE, 0);
        queue_beat(KIND_ADVANCE, 40);
        drain();

        // Random phases across several settings.
        for (int p = 0; p < 4; p++)
        begin
            reg_write(ADDR_CPB, $urandom_range(8, 48));
            reg_write(ADDR_TOL, $urandom_range(0, 8));
            queue_stream(40);
            if (p == 1)
            begin
                // Hold the sender off until every expected bit has come.
                while (beats_pending.size() > 25)
                    @(posedge clk);
                hold_sender = 1;
                while (in_valid || bits_expected.size() != 0)
                    @(posedge clk);
                hold_sender = 0;
            end
            drain();
        end
        reg_write(ADDR_CPB, 32);
        reg_write(ADDR_TOL, 3);
        queue_stream(40);
        drain();

        if (!failed)
            $display("** disk_data_separator_dpll: PASSED **");
        else
            $display("** disk_data_separator_dpll: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
